@@ sv/lcdseq_pkg.sv @@
package lcdseq_pkg;

  // Request codes
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_INSTR  = 3'd1;
  localparam logic [2:0] CMD_DATA   = 3'd2;
  localparam logic [2:0] CMD_GOTO   = 3'd3;
  localparam logic [2:0] CMD_REPEAT = 3'd4;
  localparam logic [2:0] CMD_GLYPH  = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_CMD_HOLD   = 3'd0;
  localparam logic [2:0] REG_DATA_HOLD  = 3'd1;
  localparam logic [2:0] REG_POWER_WAIT = 3'd2;
  localparam logic [2:0] REG_EXTRA_WAIT = 3'd3;
  localparam logic [2:0] REG_LINE0_BASE = 3'd4;
  localparam logic [2:0] REG_LINE1_BASE = 3'd5;
  localparam logic [2:0] REG_LINE2_BASE = 3'd6;
  localparam logic [2:0] REG_LINE3_BASE = 3'd7;

  localparam int HOLD_W = 24;
  localparam int ADDR_W = 7;
  localparam int PC_W   = 6;

  // Repeat count saturation limit and counter width
  localparam int MAX_REPEAT = 16;
  localparam int CNT_W      = $clog2(MAX_REPEAT + 1);

  // Nibble source codes
  localparam logic [1:0] NS_CONST = 2'd0;
  localparam logic [1:0] NS_HI    = 2'd1;
  localparam logic [1:0] NS_LO    = 2'd2;

  // Hold time source codes
  localparam logic [1:0] HS_CMD   = 2'd0;
  localparam logic [1:0] HS_DATA  = 2'd1;
  localparam logic [1:0] HS_POWER = 2'd2;
  localparam logic [1:0] HS_EXTRA = 2'd3;

  // Byte source codes
  localparam logic BS_VALUE = 1'b0;
  localparam logic BS_ADDR  = 1'b1;

  // Routine entry points in the control store
  localparam logic [PC_W-1:0] PC_INIT   = 6'd0;
  localparam logic [PC_W-1:0] PC_INSTR  = 6'd26;
  localparam logic [PC_W-1:0] PC_DATA   = 6'd30;
  localparam logic [PC_W-1:0] PC_GOTO   = 6'd34;
  localparam logic [PC_W-1:0] PC_GLYPH  = 6'd38;

  // Goto and glyph command prefixes
  localparam logic       GOTO_PREFIX  = 1'b1;
  localparam logic [1:0] GLYPH_PREFIX = 2'b01;

  // One control word per phase
  typedef struct packed {
    logic            rs;
    logic [1:0]      nsrc;
    logic [3:0]      nconst;
    logic            en;
    logic [1:0]      hsrc;
    logic            bsel;
    logic            last;
    logic            rep;
    logic [PC_W-1:0] tgt;
  } uword_t;

  typedef struct packed {
    logic [HOLD_W-1:0]           cmd_hold;
    logic [HOLD_W-1:0]           data_hold;
    logic [HOLD_W-1:0]           power_wait;
    logic [HOLD_W-1:0]           extra_wait;
    logic [3:0][ADDR_W-1:0]      line_base;
  } cfg_t;

  function automatic uword_t uw(input logic rs, input logic [1:0] nsrc,
                                input logic [3:0] nconst, input logic en,
                                input logic [1:0] hsrc, input logic bsel,
                                input logic last, input logic rep,
                                input logic [PC_W-1:0] tgt);
    uword_t w;
    w.rs     = rs;
    w.nsrc   = nsrc;
    w.nconst = nconst;
    w.en     = en;
    w.hsrc   = hsrc;
    w.bsel   = bsel;
    w.last   = last;
    w.rep    = rep;
    w.tgt    = tgt;
    return w;
  endfunction

endpackage

@@ sv/lcdseq_ucode_rom.sv @@
module lcdseq_ucode_rom
  import lcdseq_pkg::*;
(
  input  logic [PC_W-1:0] pc,
  output uword_t          word
);

  always_comb begin
    case (pc)
      // init: power-on wait, first nibble, extra wait, eleven more nibbles
      6'd0:  word = uw(1'b0, NS_CONST, 4'h0, 1'b0, HS_POWER, BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd1:  word = uw(1'b0, NS_CONST, 4'h3, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd2:  word = uw(1'b0, NS_CONST, 4'h3, 1'b0, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd3:  word = uw(1'b0, NS_CONST, 4'h3, 1'b0, HS_EXTRA, BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd4:  word = uw(1'b0, NS_CONST, 4'h3, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd5:  word = uw(1'b0, NS_CONST, 4'h3, 1'b0, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd6:  word = uw(1'b0, NS_CONST, 4'h3, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd7:  word = uw(1'b0, NS_CONST, 4'h3, 1'b0, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd8:  word = uw(1'b0, NS_CONST, 4'h2, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd9:  word = uw(1'b0, NS_CONST, 4'h2, 1'b0, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd10: word = uw(1'b0, NS_CONST, 4'h2, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd11: word = uw(1'b0, NS_CONST, 4'h2, 1'b0, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd12: word = uw(1'b0, NS_CONST, 4'hC, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd13: word = uw(1'b0, NS_CONST, 4'hC, 1'b0, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd14: word = uw(1'b0, NS_CONST, 4'h0, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd15: word = uw(1'b0, NS_CONST, 4'h0, 1'b0, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd16: word = uw(1'b0, NS_CONST, 4'hC, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd17: word = uw(1'b0, NS_CONST, 4'hC, 1'b0, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd18: word = uw(1'b0, NS_CONST, 4'h0, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd19: word = uw(1'b0, NS_CONST, 4'h0, 1'b0, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd20: word = uw(1'b0, NS_CONST, 4'h1, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd21: word = uw(1'b0, NS_CONST, 4'h1, 1'b0, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd22: word = uw(1'b0, NS_CONST, 4'h0, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd23: word = uw(1'b0, NS_CONST, 4'h0, 1'b0, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd24: word = uw(1'b0, NS_CONST, 4'h6, 1'b1, HS_CMD,   BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd25: word = uw(1'b0, NS_CONST, 4'h6, 1'b0, HS_CMD,   BS_VALUE, 1'b1, 1'b0, PC_INIT);
      // instruction byte; loops back while repeats remain
      6'd26: word = uw(1'b0, NS_HI, 4'h0, 1'b1, HS_CMD, BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd27: word = uw(1'b0, NS_HI, 4'h0, 1'b0, HS_CMD, BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd28: word = uw(1'b0, NS_LO, 4'h0, 1'b1, HS_CMD, BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd29: word = uw(1'b0, NS_LO, 4'h0, 1'b0, HS_CMD, BS_VALUE, 1'b1, 1'b1, PC_INSTR);
      // data byte
      6'd30: word = uw(1'b1, NS_HI, 4'h0, 1'b1, HS_DATA, BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd31: word = uw(1'b1, NS_HI, 4'h0, 1'b0, HS_DATA, BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd32: word = uw(1'b1, NS_LO, 4'h0, 1'b1, HS_DATA, BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd33: word = uw(1'b1, NS_LO, 4'h0, 1'b0, HS_DATA, BS_VALUE, 1'b1, 1'b0, PC_INIT);
      // goto: address command
      6'd34: word = uw(1'b0, NS_HI, 4'h0, 1'b1, HS_CMD, BS_ADDR, 1'b0, 1'b0, PC_INIT);
      6'd35: word = uw(1'b0, NS_HI, 4'h0, 1'b0, HS_CMD, BS_ADDR, 1'b0, 1'b0, PC_INIT);
      6'd36: word = uw(1'b0, NS_LO, 4'h0, 1'b1, HS_CMD, BS_ADDR, 1'b0, 1'b0, PC_INIT);
      6'd37: word = uw(1'b0, NS_LO, 4'h0, 1'b0, HS_CMD, BS_ADDR, 1'b1, 1'b0, PC_INIT);
      // glyph row: CGRAM address command, then row bits as data
      6'd38: word = uw(1'b0, NS_HI, 4'h0, 1'b1, HS_CMD, BS_ADDR, 1'b0, 1'b0, PC_INIT);
      6'd39: word = uw(1'b0, NS_HI, 4'h0, 1'b0, HS_CMD, BS_ADDR, 1'b0, 1'b0, PC_INIT);
      6'd40: word = uw(1'b0, NS_LO, 4'h0, 1'b1, HS_CMD, BS_ADDR, 1'b0, 1'b0, PC_INIT);
      6'd41: word = uw(1'b0, NS_LO, 4'h0, 1'b0, HS_CMD, BS_ADDR, 1'b0, 1'b0, PC_INIT);
      6'd42: word = uw(1'b1, NS_HI, 4'h0, 1'b1, HS_DATA, BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd43: word = uw(1'b1, NS_HI, 4'h0, 1'b0, HS_DATA, BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd44: word = uw(1'b1, NS_LO, 4'h0, 1'b1, HS_DATA, BS_VALUE, 1'b0, 1'b0, PC_INIT);
      6'd45: word = uw(1'b1, NS_LO, 4'h0, 1'b0, HS_DATA, BS_VALUE, 1'b1, 1'b0, PC_INIT);
      // unused addresses end the routine
      default: word = uw(1'b0, NS_CONST, 4'h0, 1'b0, HS_CMD, BS_VALUE, 1'b1, 1'b0, PC_INIT);
    endcase
  end

endmodule

@@ sv/lcdseq_cfg_regs.sv @@
module lcdseq_cfg_regs
  import lcdseq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [HOLD_W-1:0] wr_data,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_CMD_HOLD:   cfg_nxt.cmd_hold     = wr_data;
        REG_DATA_HOLD:  cfg_nxt.data_hold    = wr_data;
        REG_POWER_WAIT: cfg_nxt.power_wait   = wr_data;
        REG_EXTRA_WAIT: cfg_nxt.extra_wait   = wr_data;
        REG_LINE0_BASE: cfg_nxt.line_base[0] = wr_data[ADDR_W-1:0];
        REG_LINE1_BASE: cfg_nxt.line_base[1] = wr_data[ADDR_W-1:0];
        REG_LINE2_BASE: cfg_nxt.line_base[2] = wr_data[ADDR_W-1:0];
        REG_LINE3_BASE: cfg_nxt.line_base[3] = wr_data[ADDR_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cmd_hold     <= HOLD_W'(16000);
      cfg_r.data_hold    <= HOLD_W'(1600);
      cfg_r.power_wait   <= HOLD_W'(320000);
      cfg_r.extra_wait   <= HOLD_W'(96000);
      cfg_r.line_base[0] <= ADDR_W'(0);
      cfg_r.line_base[1] <= ADDR_W'(64);
      cfg_r.line_base[2] <= ADDR_W'(20);
      cfg_r.line_base[3] <= ADDR_W'(84);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/lcdseq_phase_dp.sv @@
module lcdseq_phase_dp
  import lcdseq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  uword_t            word,
  input  logic              last_phase,
  input  logic [7:0]        value,
  input  logic [7:0]        addr,
  input  cfg_t              cfg,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_reg_select,
  output logic [3:0]        out_nibble,
  output logic              out_enable,
  output logic [HOLD_W-1:0] out_hold_cycles,
  output logic              out_last
);

  logic              valid_r;
  logic              rs_r;
  logic [3:0]        nib_r;
  logic              en_r;
  logic [HOLD_W-1:0] hold_r;
  logic              last_r;
  logic [7:0]        byte_sel;
  logic [3:0]        nib_nxt;
  logic [HOLD_W-1:0] hold_nxt;

  // Pick the byte, then the nibble
  always_comb begin
    byte_sel = (word.bsel == BS_ADDR) ? addr : value;
    case (word.nsrc)
      NS_HI:   nib_nxt = byte_sel[7:4];
      NS_LO:   nib_nxt = byte_sel[3:0];
      default: nib_nxt = word.nconst;
    endcase
  end

  // Pick the hold time
  always_comb begin
    case (word.hsrc)
      HS_DATA:  hold_nxt = cfg.data_hold;
      HS_POWER: hold_nxt = cfg.power_wait;
      HS_EXTRA: hold_nxt = cfg.extra_wait;
      default:  hold_nxt = cfg.cmd_hold;
    endcase
  end

  assign out_free = !valid_r || !out_stall;

  // Output valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Output payload: hold while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      rs_r   <= word.rs;
      nib_r  <= nib_nxt;
      en_r   <= word.en;
      hold_r <= hold_nxt;
      last_r <= last_phase;
    end
  end

  assign out_valid       = valid_r;
  assign out_reg_select  = rs_r;
  assign out_nibble      = nib_r;
  assign out_enable      = en_r;
  assign out_hold_cycles = hold_r;
  assign out_last        = last_r;

endmodule

@@ sv/char_lcd_nibble_bus_sequencer_unit.sv @@
// Channel  Handshake            Payload
// in       in_valid / in_stall  command value column line repeat_count glyph_code glyph_row
// out      out_valid/out_stall  reg_select nibble enable hold_cycles last
// cfg      cfg_valid/cfg_ready  cfg_index (register 0..7), cfg_data (24 bit)
//
// A request runs a routine from the control store, one phase per cycle while the
// output register is free: init 26 phases, instruction/data/goto 4, glyph row 8,
// repeated instruction 4 per repeat (up to 64). in_stall stays high while a routine
// runs; the last phase reaches the output register in the cycle after it is read.
// Stalls on out hold the program counter. Sync reset restores the register defaults.
module char_lcd_nibble_bus_sequencer_unit
  import lcdseq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_command,
  input  logic [7:0]        in_value,
  input  logic [6:0]        in_column,
  input  logic [2:0]        in_line,
  input  logic [7:0]        in_repeat_count,
  input  logic [2:0]        in_glyph_code,
  input  logic [2:0]        in_glyph_row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_reg_select,
  output logic [3:0]        out_nibble,
  output logic              out_enable,
  output logic [HOLD_W-1:0] out_hold_cycles,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [HOLD_W-1:0] cfg_data
);

  cfg_t             cfg;
  uword_t           word;
  logic             busy_r, busy_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       value_r;
  logic [7:0]       addr_r, addr_nxt;
  logic             accept;
  logic             advance;
  logic             out_free;
  logic             looping;
  logic             last_phase;
  logic             start_ok;
  logic [PC_W-1:0]  entry;
  logic [CNT_W-1:0] sat_count;
  logic [1:0]       line_idx;
  logic [ADDR_W-1:0] ddram_addr;

  assign cfg_ready = 1'b1;

  lcdseq_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lcdseq_ucode_rom u_rom (
    .pc   (pc_r),
    .word (word)
  );

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign advance  = busy_r && out_free;

  // Saturate repeat count, choose the entry point
  always_comb begin
    sat_count = (in_repeat_count > 8'(MAX_REPEAT)) ? CNT_W'(MAX_REPEAT)
                                                   : in_repeat_count[CNT_W-1:0];
    start_ok  = 1'b1;
    count_nxt = CNT_W'(1);
    case (in_command)
      CMD_INIT:   entry = PC_INIT;
      CMD_INSTR:  entry = PC_INSTR;
      CMD_DATA:   entry = PC_DATA;
      CMD_GOTO:   entry = PC_GOTO;
      CMD_REPEAT: begin
        entry     = PC_INSTR;
        count_nxt = sat_count;
        start_ok  = (in_repeat_count != 8'd0);
      end
      CMD_GLYPH:  entry = PC_GLYPH;
      default: begin
        entry    = PC_INIT;
        start_ok = 1'b0;
      end
    endcase
  end

  // Build the address command byte for goto or glyph row
  always_comb begin
    line_idx   = (in_line > 3'd3) ? 2'd0 : in_line[1:0];
    ddram_addr = cfg.line_base[line_idx] + in_column;
    if (in_command == CMD_GOTO) begin
      addr_nxt = {GOTO_PREFIX, ddram_addr};
    end else begin
      addr_nxt = {GLYPH_PREFIX, in_glyph_code, in_glyph_row};
    end
  end

  // Step the program counter, loop on repeats
  always_comb begin
    looping    = word.rep && (count_r != CNT_W'(1));
    last_phase = word.last && !looping;
    busy_nxt   = busy_r;
    pc_nxt     = pc_r;
    if (accept) begin
      busy_nxt = start_ok;
      pc_nxt   = entry;
    end else if (advance) begin
      if (last_phase) begin
        busy_nxt = 1'b0;
      end else if (looping) begin
        pc_nxt = word.tgt;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_INIT;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  // Latch request operands, count down repeats
  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_value;
      addr_r  <= addr_nxt;
      count_r <= count_nxt;
    end else if (advance && looping) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  lcdseq_phase_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (advance),
    .word            (word),
    .last_phase      (last_phase),
    .value           (value_r),
    .addr            (addr_r),
    .cfg             (cfg),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reg_select  (out_reg_select),
    .out_nibble      (out_nibble),
    .out_enable      (out_enable),
    .out_hold_cycles (out_hold_cycles),
    .out_last        (out_last)
  );

endmodule
